// File: hdl/iso_timestamp_to_epoch_macros.svh
// Assertion macros shared by the timestamp converter RTL.
`ifndef ISO_TIMESTAMP_TO_EPOCH_MACROS_SVH
`define ISO_TIMESTAMP_TO_EPOCH_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITE_ASSERT_IMP(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ITE_ASSERT_NXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/ite_pkg.sv
// Types, constants and tables shared by the timestamp converter.
package ite_pkg;

    localparam int unsigned IDX_W     = 5;
    localparam int unsigned YEAR_W    = 15;
    localparam int unsigned FIELD_W   = 8;
    localparam int unsigned EPOCH_W   = 39;
    localparam int unsigned ACC_W     = 40;
    localparam int unsigned MUL_A_W   = 24;
    localparam int unsigned MUL_B_W   = 18;
    // Century count of year minus one: product bits [25:19] of the reciprocal multiply.
    localparam int unsigned QUOT_W    = 7;
    localparam int unsigned QUOT_LSB  = 19;

    // Character positions.
    localparam logic [IDX_W-1:0] MAX_POS       = 5'd25;
    localparam logic [IDX_W-1:0] MIN_LEN       = 5'd19;
    localparam logic [IDX_W-1:0] POS_DATE_SEP1 = 5'd4;
    localparam logic [IDX_W-1:0] POS_DATE_SEP2 = 5'd7;
    localparam logic [IDX_W-1:0] POS_T         = 5'd10;
    localparam logic [IDX_W-1:0] POS_TIME_SEP1 = 5'd13;
    localparam logic [IDX_W-1:0] POS_TIME_SEP2 = 5'd16;
    localparam logic [IDX_W-1:0] POS_ZONE      = 5'd19;
    localparam logic [IDX_W-1:0] POS_ZONE_SEP  = 5'd22;

    // Character codes.
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    // Arithmetic constants.
    localparam logic signed [MUL_B_W-1:0] SEC_PER_DAY   = 18'sd86400;
    localparam logic signed [MUL_B_W-1:0] SEC_PER_HOUR  = 18'sd3600;
    localparam logic signed [MUL_B_W-1:0] SEC_PER_MIN   = 18'sd60;
    localparam logic signed [MUL_B_W-1:0] DAYS_PER_YEAR = 18'sd365;
    localparam logic signed [MUL_B_W-1:0] UNIT_GAIN     = 18'sd1;
    // 2^19 / 100 rounded up; exact quotient for dividends below 43690.
    localparam logic signed [MUL_B_W-1:0] RECIP_CENT    = 18'sd5243;
    localparam logic signed [MUL_B_W-1:0] NEG_CENTURY   = -18'sd100;
    localparam logic signed [15:0]        EPOCH_YEAR    = 16'sd1970;
    localparam logic [6:0]                CENT_LAST     = 7'd99;
    // Leap days before 1970 (477) plus one for the zero-based day of month.
    localparam logic signed [MUL_A_W-1:0] DAY_BIAS      = -24'sd478;

    typedef enum logic [1:0] {PH_BLANK, PH_DIGITS, PH_DONE} t_phase;

    typedef enum logic [1:0] {ZK_NONE, ZK_UTC, ZK_PLUS, ZK_MINUS} t_zone;

    typedef enum logic [3:0] {
        FS_NONE, FS_YEAR, FS_MONTH, FS_DAY, FS_HOUR, FS_MINUTE, FS_SECOND,
        FS_ZHOUR, FS_ZMIN
    } t_fsel;

    typedef enum logic [4:0] {
        ST_IDLE, ST_LOAD, ST_QUOT, ST_REM, ST_YEAR, ST_QUAD, ST_CENT, ST_QUAD_CENT,
        ST_MONTH, ST_DAY, ST_SCALE, ST_HOUR, ST_MINUTE, ST_SECOND,
        ST_ZONE_HOUR, ST_ZONE_MIN, ST_DONE
    } t_state;

    typedef struct packed {
        logic [IDX_W-1:0]          idx;
        logic                      fmt_ok;
        t_zone                     zone;
        logic signed [YEAR_W-1:0]  year;
        logic signed [FIELD_W-1:0] month;
        logic signed [FIELD_W-1:0] day;
        logic signed [FIELD_W-1:0] hour;
        logic signed [FIELD_W-1:0] minute;
        logic signed [FIELD_W-1:0] second;
        logic signed [FIELD_W-1:0] zone_hour;
        logic signed [FIELD_W-1:0] zone_min;
    } t_fields;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
        logic                      from_zero;
        logic                      we;
    } t_mac_op;

    function automatic t_fsel field_of(input logic [IDX_W-1:0] pos);
        t_fsel f;
        unique case (pos)
            5'd0, 5'd1, 5'd2, 5'd3: f = FS_YEAR;
            5'd5, 5'd6:             f = FS_MONTH;
            5'd8, 5'd9:             f = FS_DAY;
            5'd11, 5'd12:           f = FS_HOUR;
            5'd14, 5'd15:           f = FS_MINUTE;
            5'd17, 5'd18:           f = FS_SECOND;
            5'd20, 5'd21:           f = FS_ZHOUR;
            5'd23, 5'd24:           f = FS_ZMIN;
            default:                f = FS_NONE;
        endcase
        return f;
    endfunction

    function automatic logic window_start(input logic [IDX_W-1:0] pos);
        return (pos == 5'd0) || (pos == 5'd5) || (pos == 5'd8) || (pos == 5'd11) ||
               (pos == 5'd14) || (pos == 5'd17) || (pos == 5'd20) || (pos == 5'd23);
    endfunction

    // Month length for a zero-based month, February as a common year.
    function automatic logic [4:0] month_len(input logic [3:0] m0);
        logic [4:0] d;
        unique case (m0)
            4'd1:                    d = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10: d = 5'd30;
            default:                 d = 5'd31;
        endcase
        return d;
    endfunction

    // Days in the year before the first of a zero-based month, common year.
    function automatic logic [8:0] days_before(input logic [3:0] m0);
        logic [8:0] d;
        unique case (m0)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

// File: hdl/ite_stream_if.sv
// Handshake interfaces for the character input and the result output.
interface ite_char_if;
    import ite_pkg::*;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       is_last;

    modport source (output valid, output char_code, output is_last, input ready);
    modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface ite_result_if;
    import ite_pkg::*;
    logic                      valid;
    logic                      ready;
    logic                      valid_res;
    logic signed [EPOCH_W-1:0] epoch_seconds;

    modport source (output valid, output valid_res, output epoch_seconds, input ready);
    modport sink (input valid, input valid_res, input epoch_seconds, output ready);
endinterface

// File: hdl/ite_parse.sv
// Character parser: separator checks, suffix kind and field accumulation.
module ite_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_take,
    input  logic             i_clear,
    input  logic [7:0]       i_char_code,
    output ite_pkg::t_fields o_fields
);
    import ite_pkg::*;

    logic [IDX_W-1:0]          r_idx, n_idx;
    t_phase                    r_phase, n_phase;
    logic                      r_neg, n_neg;
    logic                      r_fmt, n_fmt;
    t_zone                     r_zone, n_zone;
    logic signed [YEAR_W-1:0]  r_year, n_year;
    logic signed [FIELD_W-1:0] r_month, n_month;
    logic signed [FIELD_W-1:0] r_day, n_day;
    logic signed [FIELD_W-1:0] r_hour, n_hour;
    logic signed [FIELD_W-1:0] r_minute, n_minute;
    logic signed [FIELD_W-1:0] r_second, n_second;
    logic signed [FIELD_W-1:0] r_zhour, n_zhour;
    logic signed [FIELD_W-1:0] r_zmin, n_zmin;

    t_fsel              w_sel;
    t_phase             w_phase;
    logic               w_neg;
    logic               w_digit;
    logic               w_blank;
    logic [3:0]         w_dval;
    logic signed [15:0] w_cur;
    logic signed [15:0] w_term;
    logic signed [15:0] w_new;

    always_comb begin
        w_sel   = field_of(r_idx);
        w_phase = window_start(r_idx) ? PH_BLANK : r_phase;
        w_neg   = window_start(r_idx) ? 1'b0 : r_neg;
        w_digit = (i_char_code >= CH_ZERO) && (i_char_code <= CH_NINE);
        w_blank = (i_char_code == CH_SPACE) ||
                  ((i_char_code >= CH_TAB) && (i_char_code <= CH_CR));
        w_dval  = 4'(i_char_code - CH_ZERO);

        unique case (w_sel)
            FS_YEAR:   w_cur = 16'(r_year);
            FS_MONTH:  w_cur = 16'(r_month);
            FS_DAY:    w_cur = 16'(r_day);
            FS_HOUR:   w_cur = 16'(r_hour);
            FS_MINUTE: w_cur = 16'(r_minute);
            FS_SECOND: w_cur = 16'(r_second);
            FS_ZHOUR:  w_cur = 16'(r_zhour);
            FS_ZMIN:   w_cur = 16'(r_zmin);
            default:   w_cur = '0;
        endcase
        w_term = w_neg ? -16'(w_dval) : 16'(w_dval);
        w_new  = w_cur * 16'sd10 + w_term;

        n_idx    = r_idx;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_fmt    = r_fmt;
        n_zone   = r_zone;
        n_year   = r_year;
        n_month  = r_month;
        n_day    = r_day;
        n_hour   = r_hour;
        n_minute = r_minute;
        n_second = r_second;
        n_zhour  = r_zhour;
        n_zmin   = r_zmin;

        if (i_take && (r_idx < MAX_POS)) begin
            n_idx = r_idx + 1'b1;
            if (w_sel != FS_NONE) begin
                n_phase = w_phase;
                n_neg   = w_neg;
                if (w_digit) begin
                    if (w_phase != PH_DONE) begin
                        n_phase = PH_DIGITS;
                        unique case (w_sel)
                            FS_YEAR:   n_year   = w_new[YEAR_W-1:0];
                            FS_MONTH:  n_month  = w_new[FIELD_W-1:0];
                            FS_DAY:    n_day    = w_new[FIELD_W-1:0];
                            FS_HOUR:   n_hour   = w_new[FIELD_W-1:0];
                            FS_MINUTE: n_minute = w_new[FIELD_W-1:0];
                            FS_SECOND: n_second = w_new[FIELD_W-1:0];
                            FS_ZHOUR:  n_zhour  = w_new[FIELD_W-1:0];
                            FS_ZMIN:   n_zmin   = w_new[FIELD_W-1:0];
                            default: ;
                        endcase
                    end
                end else if ((w_phase == PH_BLANK) &&
                             ((i_char_code == CH_PLUS) || (i_char_code == CH_DASH))) begin
                    n_neg   = (i_char_code == CH_DASH);
                    n_phase = PH_DIGITS;
                end else if (!((w_phase == PH_BLANK) && w_blank)) begin
                    n_phase = PH_DONE;
                end
            end else begin
                unique case (r_idx)
                    POS_DATE_SEP1, POS_DATE_SEP2: begin
                        if (i_char_code != CH_DASH) n_fmt = 1'b0;
                    end
                    POS_T: begin
                        if (i_char_code != CH_T) n_fmt = 1'b0;
                    end
                    POS_TIME_SEP1, POS_TIME_SEP2: begin
                        if (i_char_code != CH_COLON) n_fmt = 1'b0;
                    end
                    POS_ZONE: begin
                        priority if (i_char_code == CH_Z)    n_zone = ZK_UTC;
                        else if (i_char_code == CH_PLUS)     n_zone = ZK_PLUS;
                        else if (i_char_code == CH_DASH)     n_zone = ZK_MINUS;
                        else                                 n_zone = ZK_NONE;
                    end
                    POS_ZONE_SEP: begin
                        if ((i_char_code != CH_COLON) && (r_zone != ZK_UTC)) n_zone = ZK_NONE;
                    end
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_clear) begin
            r_idx    <= '0;
            r_phase  <= PH_BLANK;
            r_neg    <= 1'b0;
            r_fmt    <= 1'b1;
            r_zone   <= ZK_NONE;
            r_year   <= '0;
            r_month  <= '0;
            r_day    <= '0;
            r_hour   <= '0;
            r_minute <= '0;
            r_second <= '0;
            r_zhour  <= '0;
            r_zmin   <= '0;
        end else begin
            r_idx    <= n_idx;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_fmt    <= n_fmt;
            r_zone   <= n_zone;
            r_year   <= n_year;
            r_month  <= n_month;
            r_day    <= n_day;
            r_hour   <= n_hour;
            r_minute <= n_minute;
            r_second <= n_second;
            r_zhour  <= n_zhour;
            r_zmin   <= n_zmin;
        end
    end

    always_comb begin
        o_fields.idx       = r_idx;
        o_fields.fmt_ok    = r_fmt;
        o_fields.zone      = r_zone;
        o_fields.year      = r_year;
        o_fields.month     = r_month;
        o_fields.day       = r_day;
        o_fields.hour      = r_hour;
        o_fields.minute    = r_minute;
        o_fields.second    = r_second;
        o_fields.zone_hour = r_zhour;
        o_fields.zone_min  = r_zmin;
    end

endmodule

// File: hdl/ite_mac.sv
// Shared multiply-add unit with its accumulator register.
module ite_mac (
    input  logic                               i_clk,
    input  ite_pkg::t_mac_op                   i_op,
    output logic signed [ite_pkg::ACC_W-1:0]   o_acc
);
    import ite_pkg::*;

    logic signed [ACC_W-1:0]           r_acc;
    logic signed [MUL_A_W+MUL_B_W-1:0] w_prod;
    logic signed [ACC_W-1:0]           w_base;
    logic signed [ACC_W-1:0]           w_sum;

    always_comb begin
        w_prod = i_op.a * i_op.b;
        w_base = i_op.from_zero ? '0 : r_acc;
        w_sum  = w_base + $signed(w_prod[ACC_W-1:0]);
    end

    always_ff @(posedge i_clk) begin
        if (i_op.we) begin
            r_acc <= w_sum;
        end
    end

    assign o_acc = r_acc;

endmodule

// File: hdl/ite_seq.sv
// Sequencer that drives the shared multiply-add unit through the date checks and sum.
module ite_seq (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_out_free,
    input  ite_pkg::t_fields                 i_fields,
    input  logic signed [ite_pkg::ACC_W-1:0] i_acc,
    output ite_pkg::t_mac_op                 o_op,
    output logic                             o_idle,
    output logic                             o_done,
    output logic                             o_ok
);
    import ite_pkg::*;

    t_state              r_state, n_state;
    logic [QUOT_W-1:0]   r_quot, n_quot;
    logic                r_ok, n_ok;
    logic                r_leap, n_leap;

    logic signed [15:0]  w_yx;
    logic                w_rem_last;
    logic                w_leap;
    logic [3:0]          w_m0;
    logic [4:0]          w_dim;
    logic                w_zone_on;
    logic                w_zone_ok;
    logic                w_ok;
    logic signed [MUL_B_W-1:0] w_zone_gain_h;
    logic signed [MUL_B_W-1:0] w_zone_gain_m;

    always_comb begin
        // Year minus one is the dividend for the century count.
        w_yx       = 16'(i_fields.year) - 16'sd1;
        // The remainder sits in the accumulator right after the century split.
        w_rem_last = (i_acc[6:0] == CENT_LAST);
        w_leap     = ((i_fields.year[1:0] == 2'b00) && !w_rem_last) ||
                     (w_rem_last && (r_quot[1:0] == 2'b11));
        w_m0       = 4'(i_fields.month[3:0] - 4'd1);
        w_dim      = ((i_fields.month == 8'sd2) && w_leap) ? 5'd29 : month_len(w_m0);
        w_zone_on  = (i_fields.idx > POS_ZONE) && (i_fields.zone != ZK_UTC);
        w_zone_ok  = !w_zone_on ||
                     ((i_fields.zone != ZK_NONE) && (i_fields.idx >= MAX_POS) &&
                      (i_fields.zone_hour <= 8'sd23) && (i_fields.zone_min <= 8'sd59));
        w_ok       = (i_fields.idx >= MIN_LEN) && i_fields.fmt_ok &&
                     (i_fields.year >= 15'sd1970) &&
                     (i_fields.month >= 8'sd1) && (i_fields.month <= 8'sd12) &&
                     (i_fields.day >= 8'sd1) && (i_fields.day <= $signed({3'b000, w_dim})) &&
                     (i_fields.hour <= 8'sd23) && (i_fields.minute <= 8'sd59) &&
                     (i_fields.second <= 8'sd59) && w_zone_ok;
        // A plus offset is taken off the local time, a minus offset added.
        w_zone_gain_h = !w_zone_on ? '0 :
                        (i_fields.zone == ZK_MINUS) ? SEC_PER_HOUR : -SEC_PER_HOUR;
        w_zone_gain_m = !w_zone_on ? '0 :
                        (i_fields.zone == ZK_MINUS) ? SEC_PER_MIN : -SEC_PER_MIN;
    end

    always_comb begin
        n_state = r_state;
        n_quot  = r_quot;
        n_ok    = r_ok;
        n_leap  = r_leap;
        o_op    = '0;
        o_done  = 1'b0;

        unique case (r_state)
            ST_IDLE: begin
                if (i_start) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                // Year minus one times the scaled reciprocal of 100.
                o_op.a         = MUL_A_W'(w_yx);
                o_op.b         = RECIP_CENT;
                o_op.from_zero = 1'b1;
                o_op.we        = 1'b1;
                n_state        = ST_QUOT;
            end
            ST_QUOT: begin
                n_quot         = i_acc[QUOT_LSB +: QUOT_W];
                o_op.a         = MUL_A_W'(w_yx);
                o_op.b         = UNIT_GAIN;
                o_op.from_zero = 1'b1;
                o_op.we        = 1'b1;
                n_state        = ST_REM;
            end
            ST_REM: begin
                o_op.a  = MUL_A_W'(r_quot);
                o_op.b  = NEG_CENTURY;
                o_op.we = 1'b1;
                n_state = ST_YEAR;
            end
            ST_YEAR: begin
                n_ok           = w_ok;
                n_leap         = w_leap;
                o_op.a         = MUL_A_W'(16'(i_fields.year) - EPOCH_YEAR);
                o_op.b         = DAYS_PER_YEAR;
                o_op.from_zero = 1'b1;
                o_op.we        = 1'b1;
                n_state        = ST_QUAD;
            end
            ST_QUAD: begin
                o_op.a  = MUL_A_W'(w_yx >>> 2);
                o_op.b  = UNIT_GAIN;
                o_op.we = 1'b1;
                n_state = ST_CENT;
            end
            ST_CENT: begin
                o_op.a  = MUL_A_W'(r_quot);
                o_op.b  = -UNIT_GAIN;
                o_op.we = 1'b1;
                n_state = ST_QUAD_CENT;
            end
            ST_QUAD_CENT: begin
                o_op.a  = MUL_A_W'(r_quot >> 2);
                o_op.b  = UNIT_GAIN;
                o_op.we = 1'b1;
                n_state = ST_MONTH;
            end
            ST_MONTH: begin
                o_op.a  = MUL_A_W'(days_before(w_m0)) +
                          MUL_A_W'(r_leap && (i_fields.month > 8'sd2)) + DAY_BIAS;
                o_op.b  = UNIT_GAIN;
                o_op.we = 1'b1;
                n_state = ST_DAY;
            end
            ST_DAY: begin
                o_op.a  = MUL_A_W'(i_fields.day);
                o_op.b  = UNIT_GAIN;
                o_op.we = 1'b1;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                o_op.a         = i_acc[MUL_A_W-1:0];
                o_op.b         = SEC_PER_DAY;
                o_op.from_zero = 1'b1;
                o_op.we        = 1'b1;
                n_state        = ST_HOUR;
            end
            ST_HOUR: begin
                o_op.a  = MUL_A_W'(i_fields.hour);
                o_op.b  = SEC_PER_HOUR;
                o_op.we = 1'b1;
                n_state = ST_MINUTE;
            end
            ST_MINUTE: begin
                o_op.a  = MUL_A_W'(i_fields.minute);
                o_op.b  = SEC_PER_MIN;
                o_op.we = 1'b1;
                n_state = ST_SECOND;
            end
            ST_SECOND: begin
                o_op.a  = MUL_A_W'(i_fields.second);
                o_op.b  = UNIT_GAIN;
                o_op.we = 1'b1;
                n_state = ST_ZONE_HOUR;
            end
            ST_ZONE_HOUR: begin
                o_op.a  = MUL_A_W'(i_fields.zone_hour);
                o_op.b  = w_zone_gain_h;
                o_op.we = 1'b1;
                n_state = ST_ZONE_MIN;
            end
            ST_ZONE_MIN: begin
                o_op.a  = MUL_A_W'(i_fields.zone_min);
                o_op.b  = w_zone_gain_m;
                o_op.we = 1'b1;
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_quot  <= '0;
            r_ok    <= 1'b0;
            r_leap  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_quot  <= n_quot;
            r_ok    <= n_ok;
            r_leap  <= n_leap;
        end
    end

    assign o_idle = (r_state == ST_IDLE);
    assign o_ok   = r_ok;

endmodule

// File: hdl/iso_timestamp_to_epoch.sv
// Top level of the ISO-8601 timestamp to Unix epoch converter.
// The block takes a timestamp of the form YYYY-MM-DDTHH:MM:SS, optionally followed by Z or by
// +HH:MM / -HH:MM, one byte per transfer on i_char, with is_last set on the final byte. Every
// byte but the last is taken while the sequencer is idle, so a string streams in at one
// character per clock. The last byte starts the evaluation, which runs on one shared multiply-add
// unit under a sequencer: the load, quotient and remainder steps split year minus one into
// centuries and a remainder by multiplying with a scaled reciprocal of 100 and subtracting the
// centuries back out, then twelve multiply-add steps for the day count and the seconds, and a final
// step hands the result to the output register. i_char.ready is low throughout; that step waits
// only while the output register still holds an untaken result. The next string may start
// while that result still waits on o_result; a second result only waits if the first has not
// been taken by the end of its evaluation. Each result transfer carries valid_res (the string
// parsed and passed all range checks) and epoch_seconds, which is zero whenever valid_res is
// low. Fields are read as atoi reads them: leading blanks, an optional sign, then digits up
// to the first non-digit; characters past the 25th are ignored.
`include "iso_timestamp_to_epoch_macros.svh"

module iso_timestamp_to_epoch (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ite_char_if.sink     i_char,
    ite_result_if.source o_result
);
    import ite_pkg::*;

    logic                    w_take;
    logic                    w_start;
    logic                    w_idle;
    logic                    w_done;
    logic                    w_ok;
    logic                    w_out_free;
    logic signed [ACC_W-1:0] w_acc;
    t_fields                 w_fields;
    t_mac_op                 w_op;

    // Output register: holds one finished result until the sink takes it.
    logic                      r_out_valid;
    logic                      r_out_res;
    logic signed [EPOCH_W-1:0] r_out_sec;

    assign w_take     = i_char.valid && i_char.ready;
    assign w_start    = w_take && i_char.is_last;
    assign w_out_free = !r_out_valid || o_result.ready;

    assign i_char.ready = w_idle;

    ite_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_take      (w_take),
        .i_clear     (w_done),
        .i_char_code (i_char.char_code),
        .o_fields    (w_fields)
    );

    ite_mac u_mac (
        .i_clk     (i_clk),
        .i_op      (w_op),
        .o_acc     (w_acc)
    );

    ite_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_out_free (w_out_free),
        .i_fields   (w_fields),
        .i_acc      (w_acc),
        .o_op       (w_op),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_ok       (w_ok)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // An invalid string reports zero seconds, whatever the accumulator holds.
    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out_res <= w_ok;
            r_out_sec <= w_ok ? w_acc[EPOCH_W-1:0] : '0;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.valid_res     = r_out_res;
    assign o_result.epoch_seconds = r_out_sec;

    `ITE_ASSERT_NXT(a_busy_after_last, i_clk, i_rst_n, w_start, !i_char.ready, "input ready after last character")
    `ITE_ASSERT_IMP(a_invalid_is_zero, i_clk, i_rst_n, o_result.valid && !o_result.valid_res, o_result.epoch_seconds == '0, "invalid result with nonzero seconds")
    `ITE_ASSERT_NXT(a_parser_cleared, i_clk, i_rst_n, w_done, (w_fields.idx == '0) && w_fields.fmt_ok && (w_fields.zone == ZK_NONE), "parser state not cleared after result")
    `ITE_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, w_done, !r_out_valid || o_result.ready, "pending result overwritten")

endmodule
